// File: sv/ls2s_pkg.sv
// package: shared types, widths and status codes for the 2x2 linear system solver
package ls2s_pkg;

    localparam int W        = 32;            // Q16.16 field width
    localparam int PW       = 2 * W;         // full product width
    localparam int CW       = PW + 1;        // cross difference width
    localparam int MW       = PW;            // cross magnitude width
    localparam int FRAC     = 16;            // fraction bits of Q16.16
    localparam int NW       = MW + FRAC + 1; // rounded, scaled numerator width
    localparam int QW       = W + 2;         // quotient bits incl. overflow bit
    localparam int CMPW     = MW + QW;       // divisor shifted to top quotient bit
    localparam int DIV_STAGES = QW;          // one quotient bit per stage

    localparam logic [1:0] STATUS_UNIQUE   = 2'd0;
    localparam logic [1:0] STATUS_INFINITE = 2'd1;
    localparam logic [1:0] STATUS_NONE     = 2'd2;
    localparam logic [1:0] STATUS_SAT      = 2'd3;

    // input word: one system of two equations
    typedef struct packed {
        logic signed [W-1:0] coef_x_first;
        logic signed [W-1:0] coef_y_first;
        logic signed [W-1:0] rhs_first;
        logic signed [W-1:0] coef_x_second;
        logic signed [W-1:0] coef_y_second;
        logic signed [W-1:0] rhs_second;
    } ls2s_sys_t;

    // output word: solution and status
    typedef struct packed {
        logic signed [W-1:0] sol_x;
        logic signed [W-1:0] sol_y;
        logic [1:0]          status;
    } ls2s_sol_t;

endpackage

// File: sv/linear_system_2x2_solver_core.sv
// Solves a 2x2 linear system by Cramer's rule with a fully pipelined datapath.
// A new system word is taken every cycle unless an output stall has backed up
// to the input; each word passes through one multiply stage, one cross-difference
// stage, one magnitude stage, one numerator stage, 34 restoring-division stages
// producing one quotient bit each for x and y in parallel, and the output
// register. Stalls at the output hold the pipeline back stage by stage, so empty
// stages still fill while the output word waits. Quotients round to nearest with
// ties away from zero and saturate to the Q16.16 range with status 3; degenerate
// rows and singular systems report status 1 or 2 with zero solutions.
module linear_system_2x2_solver_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sys_valid,
    output logic                sys_ready,
    input  ls2s_pkg::ls2s_sys_t sys,
    output logic                sol_valid,
    input  logic                sol_ready,
    output ls2s_pkg::ls2s_sol_t sol
);

    typedef struct packed {
        logic signed [ls2s_pkg::PW-1:0] a1b2;
        logic signed [ls2s_pkg::PW-1:0] a2b1;
        logic signed [ls2s_pkg::PW-1:0] c1b2;
        logic signed [ls2s_pkg::PW-1:0] c2b1;
        logic signed [ls2s_pkg::PW-1:0] a1c2;
        logic signed [ls2s_pkg::PW-1:0] a2c1;
        logic                           row_spec;
        logic [1:0]                     row_status;
    } prod_t;

    typedef struct packed {
        logic signed [ls2s_pkg::CW-1:0] det;
        logic signed [ls2s_pkg::CW-1:0] dx;
        logic signed [ls2s_pkg::CW-1:0] dy;
        logic                           row_spec;
        logic [1:0]                     row_status;
    } cross_t;

    typedef struct packed {
        logic [ls2s_pkg::MW-1:0] d;
        logic [ls2s_pkg::MW-1:0] mx;
        logic [ls2s_pkg::MW-1:0] my;
        logic                    neg_x;
        logic                    neg_y;
        logic                    spec;
        logic [1:0]              spec_status;
    } mag_t;

    typedef struct packed {
        logic [ls2s_pkg::MW-1:0] d;
        logic [ls2s_pkg::NW-1:0] rx;
        logic [ls2s_pkg::NW-1:0] ry;
        logic [ls2s_pkg::QW-1:0] qx;
        logic [ls2s_pkg::QW-1:0] qy;
        logic                    neg_x;
        logic                    neg_y;
        logic                    spec;
        logic [1:0]              spec_status;
    } div_t;

    prod_t     prod_reg;
    logic      prod_v_reg;
    cross_t    cross_reg;
    logic      cross_v_reg;
    mag_t      mag_reg;
    logic      mag_v_reg;
    div_t      div_reg   [0:ls2s_pkg::DIV_STAGES];
    logic      div_v_reg [0:ls2s_pkg::DIV_STAGES];
    div_t      div_next  [1:ls2s_pkg::DIV_STAGES];
    ls2s_pkg::ls2s_sol_t sol_reg;
    ls2s_pkg::ls2s_sol_t sol_next;
    logic      sol_v_reg;

    logic      en_out;
    logic      en_div [0:ls2s_pkg::DIV_STAGES];
    logic      en_mag;
    logic      en_cross;
    logic      en_prod;

    prod_t     prod_next;
    cross_t    cross_next;
    mag_t      mag_next;
    div_t      num_next;

    // stage enables: a stage loads when empty or when its successor moves on
    always_comb
    begin
        en_out = !sol_v_reg || sol_ready;
        en_div[ls2s_pkg::DIV_STAGES] = !div_v_reg[ls2s_pkg::DIV_STAGES] || en_out;
        for (int j = ls2s_pkg::DIV_STAGES - 1; j >= 0; j--)
        begin
            en_div[j] = !div_v_reg[j] || en_div[j+1];
        end
        en_mag   = !mag_v_reg || en_div[0];
        en_cross = !cross_v_reg || en_mag;
        en_prod  = !prod_v_reg || en_cross;
    end

    assign sys_ready = en_prod;

    // products and all-zero row checks
    always_comb
    begin
        prod_next.a1b2 = ls2s_pkg::PW'(sys.coef_x_first)  * ls2s_pkg::PW'(sys.coef_y_second);
        prod_next.a2b1 = ls2s_pkg::PW'(sys.coef_x_second) * ls2s_pkg::PW'(sys.coef_y_first);
        prod_next.c1b2 = ls2s_pkg::PW'(sys.rhs_first)     * ls2s_pkg::PW'(sys.coef_y_second);
        prod_next.c2b1 = ls2s_pkg::PW'(sys.rhs_second)    * ls2s_pkg::PW'(sys.coef_y_first);
        prod_next.a1c2 = ls2s_pkg::PW'(sys.coef_x_first)  * ls2s_pkg::PW'(sys.rhs_second);
        prod_next.a2c1 = ls2s_pkg::PW'(sys.coef_x_second) * ls2s_pkg::PW'(sys.rhs_first);
        prod_next.row_spec   = 1'b0;
        prod_next.row_status = ls2s_pkg::STATUS_UNIQUE;
        if (sys.coef_x_first == '0 && sys.coef_y_first == '0)
        begin
            prod_next.row_spec   = 1'b1;
            prod_next.row_status = (sys.rhs_first == '0) ? ls2s_pkg::STATUS_INFINITE
                                                         : ls2s_pkg::STATUS_NONE;
        end
        else if (sys.coef_x_second == '0 && sys.coef_y_second == '0)
        begin
            prod_next.row_spec   = 1'b1;
            prod_next.row_status = (sys.rhs_second == '0) ? ls2s_pkg::STATUS_INFINITE
                                                          : ls2s_pkg::STATUS_NONE;
        end
    end

    // determinant and numerators
    always_comb
    begin
        cross_next.det = ls2s_pkg::CW'(prod_reg.a1b2) - ls2s_pkg::CW'(prod_reg.a2b1);
        cross_next.dx  = ls2s_pkg::CW'(prod_reg.c1b2) - ls2s_pkg::CW'(prod_reg.c2b1);
        cross_next.dy  = ls2s_pkg::CW'(prod_reg.a1c2) - ls2s_pkg::CW'(prod_reg.a2c1);
        cross_next.row_spec   = prod_reg.row_spec;
        cross_next.row_status = prod_reg.row_status;
    end

    // magnitudes, result signs and singular classification
    always_comb
    begin
        logic signed [ls2s_pkg::CW-1:0] ad;
        logic signed [ls2s_pkg::CW-1:0] ax;
        logic signed [ls2s_pkg::CW-1:0] ay;
        logic det_s;
        logic dx_s;
        logic dy_s;
        det_s = cross_reg.det[ls2s_pkg::CW-1];
        dx_s  = cross_reg.dx[ls2s_pkg::CW-1];
        dy_s  = cross_reg.dy[ls2s_pkg::CW-1];
        ad = det_s ? -cross_reg.det : cross_reg.det;
        ax = dx_s  ? -cross_reg.dx  : cross_reg.dx;
        ay = dy_s  ? -cross_reg.dy  : cross_reg.dy;
        mag_next.d     = ad[ls2s_pkg::MW-1:0];
        mag_next.mx    = ax[ls2s_pkg::MW-1:0];
        mag_next.my    = ay[ls2s_pkg::MW-1:0];
        mag_next.neg_x = dx_s ^ det_s;
        mag_next.neg_y = dy_s ^ det_s;
        mag_next.spec        = cross_reg.row_spec;
        mag_next.spec_status = cross_reg.row_status;
        if (!cross_reg.row_spec && cross_reg.det == '0)
        begin
            mag_next.spec        = 1'b1;
            mag_next.spec_status = (cross_reg.dx == '0 && cross_reg.dy == '0)
                                 ? ls2s_pkg::STATUS_INFINITE : ls2s_pkg::STATUS_NONE;
        end
    end

    // scaled numerators with half divisor added for rounding
    always_comb
    begin
        logic [ls2s_pkg::NW-1:0] half;
        half = ls2s_pkg::NW'(mag_reg.d >> 1);
        num_next.d  = mag_reg.d;
        num_next.rx = (ls2s_pkg::NW'(mag_reg.mx) << ls2s_pkg::FRAC) + half;
        num_next.ry = (ls2s_pkg::NW'(mag_reg.my) << ls2s_pkg::FRAC) + half;
        num_next.qx = '0;
        num_next.qy = '0;
        num_next.neg_x = mag_reg.neg_x;
        num_next.neg_y = mag_reg.neg_y;
        num_next.spec  = mag_reg.spec;
        num_next.spec_status = mag_reg.spec_status;
    end

    // restoring division, one quotient bit per stage, top bit flags overflow
    for (genvar j = 0; j < ls2s_pkg::DIV_STAGES; j++)
    begin : g_div
        localparam int SH = ls2s_pkg::QW - 1 - j;
        always_comb
        begin
            logic [ls2s_pkg::CMPW-1:0] dsh;
            logic [ls2s_pkg::CMPW-1:0] rxe;
            logic [ls2s_pkg::CMPW-1:0] rye;
            logic gx;
            logic gy;
            dsh = ls2s_pkg::CMPW'(div_reg[j].d) << SH;
            rxe = ls2s_pkg::CMPW'(div_reg[j].rx);
            rye = ls2s_pkg::CMPW'(div_reg[j].ry);
            gx  = rxe >= dsh;
            gy  = rye >= dsh;
            div_next[j+1]    = div_reg[j];
            div_next[j+1].rx = gx ? ls2s_pkg::NW'(rxe - dsh) : div_reg[j].rx;
            div_next[j+1].ry = gy ? ls2s_pkg::NW'(rye - dsh) : div_reg[j].ry;
            div_next[j+1].qx = {div_reg[j].qx[ls2s_pkg::QW-2:0], gx};
            div_next[j+1].qy = {div_reg[j].qy[ls2s_pkg::QW-2:0], gy};
        end
    end

    // sign, saturation and status
    always_comb
    begin
        div_t f;
        logic [ls2s_pkg::QW-1:0] lim_x;
        logic [ls2s_pkg::QW-1:0] lim_y;
        logic sat_x;
        logic sat_y;
        logic [ls2s_pkg::W-1:0] qxl;
        logic [ls2s_pkg::W-1:0] qyl;
        f = div_reg[ls2s_pkg::DIV_STAGES];
        lim_x = f.neg_x ? (ls2s_pkg::QW'(1) << (ls2s_pkg::W - 1))
                        : ((ls2s_pkg::QW'(1) << (ls2s_pkg::W - 1)) - ls2s_pkg::QW'(1));
        lim_y = f.neg_y ? (ls2s_pkg::QW'(1) << (ls2s_pkg::W - 1))
                        : ((ls2s_pkg::QW'(1) << (ls2s_pkg::W - 1)) - ls2s_pkg::QW'(1));
        sat_x = f.qx > lim_x;
        sat_y = f.qy > lim_y;
        qxl = f.qx[ls2s_pkg::W-1:0];
        qyl = f.qy[ls2s_pkg::W-1:0];
        if (sat_x)
            sol_next.sol_x = f.neg_x ? {1'b1, {(ls2s_pkg::W-1){1'b0}}}
                                     : {1'b0, {(ls2s_pkg::W-1){1'b1}}};
        else
            sol_next.sol_x = f.neg_x ? -qxl : qxl;
        if (sat_y)
            sol_next.sol_y = f.neg_y ? {1'b1, {(ls2s_pkg::W-1){1'b0}}}
                                     : {1'b0, {(ls2s_pkg::W-1){1'b1}}};
        else
            sol_next.sol_y = f.neg_y ? -qyl : qyl;
        sol_next.status = (sat_x || sat_y) ? ls2s_pkg::STATUS_SAT : ls2s_pkg::STATUS_UNIQUE;
        if (f.spec)
        begin
            sol_next.sol_x  = '0;
            sol_next.sol_y  = '0;
            sol_next.status = f.spec_status;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg  <= 1'b0;
            cross_v_reg <= 1'b0;
            mag_v_reg   <= 1'b0;
            sol_v_reg   <= 1'b0;
            for (int j = 0; j <= ls2s_pkg::DIV_STAGES; j++)
            begin
                div_v_reg[j] <= 1'b0;
            end
        end
        else
        begin
            if (en_prod)  prod_v_reg  <= sys_valid;
            if (en_cross) cross_v_reg <= prod_v_reg;
            if (en_mag)   mag_v_reg   <= cross_v_reg;
            if (en_div[0]) div_v_reg[0] <= mag_v_reg;
            for (int j = 1; j <= ls2s_pkg::DIV_STAGES; j++)
            begin
                if (en_div[j]) div_v_reg[j] <= div_v_reg[j-1];
            end
            if (en_out) sol_v_reg <= div_v_reg[ls2s_pkg::DIV_STAGES];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en_prod)   prod_reg   <= prod_next;
        if (en_cross)  cross_reg  <= cross_next;
        if (en_mag)    mag_reg    <= mag_next;
        if (en_div[0]) div_reg[0] <= num_next;
        for (int j = 1; j <= ls2s_pkg::DIV_STAGES; j++)
        begin
            if (en_div[j]) div_reg[j] <= div_next[j];
        end
        if (en_out) sol_reg <= sol_next;
    end

    assign sol_valid = sol_v_reg;
    assign sol       = sol_reg;

    // checks
    a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
        sol_valid && (sol.status == ls2s_pkg::STATUS_INFINITE ||
                      sol.status == ls2s_pkg::STATUS_NONE)
        |-> sol.sol_x == '0 && sol.sol_y == '0)
        else $error("nonzero solution with non-unique status");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !sys_ready |-> sol_valid && !sol_ready)
        else $error("input stalled while output side is free");

    a_first_hold: assert property (@(posedge clk) disable iff (!rst_n)
        prod_v_reg && !en_cross |=> prod_v_reg && $stable(prod_reg))
        else $error("first stage lost its word during a stall");

endmodule

// File: sim/tb.sv
// testbench for the 2x2 linear system solver: directed and random systems checked against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 39;
    localparam int MAX_CYCLE = 400000;

    logic                clk;
    logic                rst_n;
    logic                sys_valid;
    logic                sys_ready;
    ls2s_pkg::ls2s_sys_t sys;
    logic                sol_valid;
    logic                sol_ready;
    ls2s_pkg::ls2s_sol_t sol;

    ls2s_pkg::ls2s_sol_t expected_sols[$];
    int         n_errors;
    int         n_checked;
    int         n_sent;
    int         cycle_count;
    int         long_hold;
    bit         random_gaps;

    linear_system_2x2_solver_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sys_valid (sys_valid),
        .sys_ready (sys_ready),
        .sys       (sys),
        .sol_valid (sol_valid),
        .sol_ready (sol_ready),
        .sol       (sol)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > MAX_CYCLE)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // rounded, saturated quotient num/den in Q16.16
    function automatic logic [31:0] quotient_q16(logic signed [66:0] num,
                                                 logic signed [66:0] den,
                                                 inout bit clamped);
        logic [66:0]  mag_n;
        logic [66:0]  mag_d;
        logic [130:0] scaled;
        logic [130:0] q;
        bit           neg;
        neg    = (num < 0) != (den < 0);
        mag_n  = (num < 0) ? -num : num;
        mag_d  = (den < 0) ? -den : den;
        scaled = ({64'd0, mag_n} << 16) + {64'd0, mag_d >> 1};
        q      = scaled / {64'd0, mag_d};
        if (neg)
        begin
            if (q > 131'h80000000)
            begin
                clamped = 1;
                return 32'h80000000;
            end
            return -q[31:0];
        end
        if (q > 131'h7FFFFFFF)
        begin
            clamped = 1;
            return 32'h7FFFFFFF;
        end
        return q[31:0];
    endfunction

    // solve one system the way the block should
    function automatic ls2s_pkg::ls2s_sol_t solve_system(ls2s_pkg::ls2s_sys_t s);
        ls2s_pkg::ls2s_sol_t r;
        logic signed [66:0]  a1, b1, c1, a2, b2, c2, det, dx, dy;
        bit                  clamped;
        r = '0;
        clamped = 0;
        a1 = s.coef_x_first;  b1 = s.coef_y_first;  c1 = s.rhs_first;
        a2 = s.coef_x_second; b2 = s.coef_y_second; c2 = s.rhs_second;
        if (a1 == 0 && b1 == 0)
        begin
            r.status = (c1 == 0) ? ls2s_pkg::STATUS_INFINITE : ls2s_pkg::STATUS_NONE;
            return r;
        end
        if (a2 == 0 && b2 == 0)
        begin
            r.status = (c2 == 0) ? ls2s_pkg::STATUS_INFINITE : ls2s_pkg::STATUS_NONE;
            return r;
        end
        det = a1 * b2 - a2 * b1;
        dx  = c1 * b2 - c2 * b1;
        dy  = a1 * c2 - a2 * c1;
        if (det == 0)
        begin
            r.status = (dx == 0 && dy == 0) ? ls2s_pkg::STATUS_INFINITE
                                            : ls2s_pkg::STATUS_NONE;
            return r;
        end
        r.sol_x  = quotient_q16(dx, det, clamped);
        r.sol_y  = quotient_q16(dy, det, clamped);
        r.status = clamped ? ls2s_pkg::STATUS_SAT : ls2s_pkg::STATUS_UNIQUE;
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (!random_gaps || p < 55)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // send one system word; valid drops only when a gap follows
    task automatic send_system(ls2s_pkg::ls2s_sys_t s);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            sys_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        sys_valid <= 1'b1;
        sys       <= s;
        expected_sols.push_back(solve_system(s));
        @(posedge clk);
        while (!sys_ready)
            @(posedge clk);
        n_sent++;
    endtask

    // receiver back-pressure
    initial
    begin
        sol_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold > 0)
            begin
                sol_ready <= 1'b0;
                long_hold--;
            end
            else if (random_gaps && $urandom_range(0, 99) < 30)
                sol_ready <= ($urandom_range(0, 9) == 0) ? 1'b1 : 1'b0;
            else
                sol_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && sol_valid && sol_ready)
        begin
            ls2s_pkg::ls2s_sol_t e;
            if (expected_sols.size() == 0)
            begin
                $display("%0t: unexpected solution word %h", $time, sol);
                n_errors++;
            end
            else
            begin
                e = expected_sols.pop_front();
                n_checked++;
                if (sol.sol_x !== e.sol_x)
                begin
                    $display("%0t: sol_x expected %h actual %h", $time, e.sol_x, sol.sol_x);
                    n_errors++;
                end
                if (sol.sol_y !== e.sol_y)
                begin
                    $display("%0t: sol_y expected %h actual %h", $time, e.sol_y, sol.sol_y);
                    n_errors++;
                end
                if (sol.status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status,
                             sol.status);
                    n_errors++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'd0;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000;
            4: return $urandom_range(0, 1) ? 32'd1 : 32'hFFFFFFFF;
            5, 6: return $signed($urandom_range(0, 2047) - 1024) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic ls2s_pkg::ls2s_sys_t make_sys(logic [31:0] a1, logic [31:0] b1,
                                                     logic [31:0] c1, logic [31:0] a2,
                                                     logic [31:0] b2, logic [31:0] c2);
        ls2s_pkg::ls2s_sys_t s;
        s.coef_x_first  = a1; s.coef_y_first  = b1; s.rhs_first  = c1;
        s.coef_x_second = a2; s.coef_y_second = b2; s.rhs_second = c2;
        return s;
    endfunction

    // stop offering and wait until every expected solution has come back
    task automatic wait_drained();
        sys_valid <= 1'b0;
        while (expected_sols.size() != 0)
            @(posedge clk);
    endtask

    // directed corners: degenerate rows, singular systems, rounding, saturation
    task automatic test_directed();
        localparam logic [31:0] ONE = 32'h00010000;
        localparam logic [31:0] MN  = 32'h80000000;
        localparam logic [31:0] MX  = 32'h7FFFFFFF;
        send_system(make_sys(0, 0, 0, ONE, ONE, ONE));
        send_system(make_sys(0, 0, ONE, ONE, ONE, ONE));
        send_system(make_sys(0, 0, 0, 0, 0, 0));
        send_system(make_sys(ONE, 0, ONE, 0, 0, 0));
        send_system(make_sys(ONE, 0, ONE, 0, 0, MN));
        send_system(make_sys(ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE));
        send_system(make_sys(ONE, ONE, ONE, 2*ONE, 2*ONE, 3*ONE));
        send_system(make_sys(0, ONE, ONE, 0, 2*ONE, ONE));
        send_system(make_sys(ONE, 0, ONE, ONE, 0, ONE));
        send_system(make_sys(ONE, 0, 3*ONE, 0, ONE, -5*ONE));
        send_system(make_sys(2*ONE, ONE, 5*ONE, ONE, 3*ONE, 10*ONE));
        send_system(make_sys(3*ONE, 0, ONE, 0, 3*ONE, 2*ONE));
        send_system(make_sys(3*ONE, 0, -ONE, 0, 3*ONE, -2*ONE));
        send_system(make_sys(2, 0, 1, 0, 2, -1));
        send_system(make_sys(1, 0, MX, 0, 1, MN));
        send_system(make_sys(1, 0, MN, 0, -1, MN));
        send_system(make_sys(MN, MN, MN, MN, MX, MX));
        send_system(make_sys(MX, MX, MX, MN, MN, MN));
        send_system(make_sys(MX, MN, MX, MN, MX, MN));
        send_system(make_sys(ONE, 0, MX, 0, ONE, MN));
        send_system(make_sys(MN, 0, MN, 0, MN, MX));
        send_system(make_sys(32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1));
        wait_drained();
    endtask

    // random systems, mostly well-conditioned, some noise and singular ones
    task automatic test_random(int count);
        ls2s_pkg::ls2s_sys_t s;
        logic [31:0] k;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0: s = make_sys($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                1:
                begin
                    s = make_sys(rand_field(), rand_field(), rand_field(), 0, 0, 0);
                    k = $urandom_range(1, 4);
                    s.coef_x_second = s.coef_x_first * k;
                    s.coef_y_second = s.coef_y_first * k;
                    s.rhs_second    = $urandom_range(0, 1) ? s.rhs_first * k : rand_field();
                end
                2: s = make_sys(rand_field(), rand_field(), rand_field(),
                                rand_field(), rand_field(), rand_field());
                default: s = make_sys($signed($urandom_range(0, 65535) - 32768) <<< 10,
                                      $signed($urandom_range(0, 65535) - 32768) <<< 10,
                                      $urandom, $signed($urandom_range(0, 65535) - 32768) <<< 10,
                                      $signed($urandom_range(0, 65535) - 32768) <<< 10,
                                      $urandom);
            endcase
            send_system(s);
        end
    endtask

    // receiver holds off for a long stretch while systems keep coming back to back
    task automatic test_backpressure();
        random_gaps = 0;
        long_hold   = 150;
        test_random(120);
        wait_drained();
        random_gaps = 1;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        sys_valid   = 1'b0;
        sys         = '0;
        n_errors    = 0;
        n_checked   = 0;
        n_sent      = 0;
        long_hold   = 0;
        random_gaps = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        random_gaps = 1;
        test_random(600);
        wait_drained();
        test_backpressure();
        random_gaps = 0;
        test_random(300);
        random_gaps = 1;
        test_random(400);
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        $display("tb: %0d systems sent, %0d solutions checked (degenerate, singular,", n_sent,
                 n_checked);
        $display("tb: rounding and saturation cases with random stalls on both sides)");
        if (n_errors == 0 && expected_sols.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// File: linear_system_2x2_solver_core.f
sv/ls2s_pkg.sv
sv/linear_system_2x2_solver_core.sv
sim/tb.sv
